/* rtl/assert_macros.svh */
// Assertion macros shared by the checker modules of the project.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/sdm_pkg.sv */
// Shared constants and types of the stack with delete-middle.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package sdm_pkg;

  localparam int DEPTH = 128;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/stack_with_delete_middle.sv */
// A finished result goes to the output register at once if free, else it waits in S_DONE.
// Push, refused ops, delete on an empty stack and unused kinds finish in S_IDLE; pop reads the
// top in S_IDLE, ends in S_POP; delete shifts the words above the middle down, one word a cycle.
// Throughput: the input stalls until the current item is done and its result has left for the
// output register, so pushes can follow one per cycle while result beats drain.
// Reset (synchronous, active high) empties the stack and drops any pending result.
`default_nettype none

module stack_with_delete_middle (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sdm_pkg::KIND_W-1:0]   kind,
  input  wire logic signed [sdm_pkg::DATA_W-1:0] push_value,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [sdm_pkg::DATA_W-1:0] pop_data,
  output logic [sdm_pkg::STATUS_W-1:0]      status,
  output logic [sdm_pkg::COUNT_W-1:0]       count
);

  import sdm_pkg::*;

  // The stack words live in a synchronous memory with a registered read.
  // Entry 0 is the bottom; fill is the number of valid entries.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  state_t            state, state_next;
  logic [CW-1:0]     fill, fill_next;
  logic [AW-1:0]     wr_ptr, wr_ptr_next;

  // Result held back while the output register is still occupied.
  logic [DATA_W-1:0]   res_data, res_data_next;
  logic [STATUS_W-1:0] res_status, res_status_next;

  logic                accept;
  logic                out_free;
  logic                finish;
  logic [DATA_W-1:0]   fin_data;
  logic [STATUS_W-1:0] fin_status;
  logic                load;
  logic [DATA_W-1:0]   ld_data;
  logic [STATUS_W-1:0] ld_status;
  logic [CW-1:0]       fill_m1;
  logic [CW-1:0]       mid;

  // New items are taken only between operations; a result waiting in the output
  // register does not hold up the next item.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign fill_m1  = fill - CW'(1);
  assign mid      = fill_m1 >> 1;

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    wr_ptr_next     = wr_ptr;
    res_data_next   = res_data;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = wr_ptr;
    mem_wdata       = rd_q;
    mem_re          = 1'b0;
    mem_raddr       = wr_ptr;
    finish          = 1'b0;
    fin_data        = '0;
    fin_status      = ST_OK;
    load            = 1'b0;
    ld_data         = res_data;
    ld_status       = res_status;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUSH: begin
              finish = 1'b1;
              if (fill >= CW'(DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(fill);
                mem_wdata = push_value;
                fill_next = fill + CW'(1);
              end
            end
            KIND_POP: begin
              if (fill == '0) begin
                finish     = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                // The top word arrives from the memory in the next cycle.
                mem_re     = 1'b1;
                mem_raddr  = AW'(fill_m1);
                fill_next  = fill_m1;
                state_next = S_POP;
              end
            end
            KIND_DEL: begin
              if (fill == '0) begin
                finish = 1'b1;
              end else begin
                fill_next = fill_m1;
                if (mid < fill_m1) begin
                  // Start the shift: fetch the word just above the middle one.
                  mem_re      = 1'b1;
                  mem_raddr   = AW'(mid + CW'(1));
                  wr_ptr_next = AW'(mid);
                  state_next  = S_SHIFT;
                end else begin
                  finish = 1'b1;
                end
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        finish   = 1'b1;
        fin_data = rd_q;
      end
      S_SHIFT: begin
        // Write the word fetched last cycle one place down, and fetch the next
        // one; read and write addresses never coincide.
        mem_we    = 1'b1;
        mem_waddr = wr_ptr;
        mem_wdata = rd_q;
        if ((CW'(wr_ptr) + CW'(1)) < fill) begin
          mem_re      = 1'b1;
          mem_raddr   = wr_ptr + AW'(2);
          wr_ptr_next = wr_ptr + AW'(1);
        end else begin
          finish = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A finished operation goes straight to the output register when it is free,
    // otherwise it waits in the result holding registers.
    if (finish) begin
      if (out_free) begin
        load       = 1'b1;
        ld_data    = fin_data;
        ld_status  = fin_status;
        state_next = S_IDLE;
      end else begin
        res_data_next   = fin_data;
        res_status_next = fin_status;
        state_next      = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    wr_ptr     <= wr_ptr_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    if (load) begin
      pop_data <= ld_data;
      status   <= ld_status;
      count    <= COUNT_W'(fill_next);
    end
  end

  // Stack store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sdm_checker.sv */
// Port-level checker for the stack with delete-middle, bound to the top level.
// Depends on sdm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sdm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic [sdm_pkg::KIND_W-1:0]        kind,
  input wire logic signed [sdm_pkg::DATA_W-1:0] push_value,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [sdm_pkg::DATA_W-1:0] pop_data,
  input wire logic [sdm_pkg::STATUS_W-1:0]      status,
  input wire logic [sdm_pkg::COUNT_W-1:0]       count
);

  import sdm_pkg::*;

  // A refused push can only happen with the stack full.
  `ASSERT_CLK(a_full_at_depth, out_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH), "full status with stack not full")

  // A refused pop leaves an empty stack and returns no data.
  `ASSERT_CLK(a_empty_pop, out_valid && status == ST_EMPTY |-> count == '0 && pop_data == '0, "empty status with data or elements")

  // Only a successful pop returns a nonzero word, and it leaves room for a push.
  `ASSERT_CLK(a_data_ok, out_valid && pop_data != '0 |-> status == ST_OK && count != COUNT_W'(DEPTH), "popped data with bad status or count")

  // A stalled result beat holds.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(pop_data) && $stable(status) && $stable(count), "stalled result changed")

endmodule

bind stack_with_delete_middle sdm_checker u_sdm_checker (.*);

`default_nettype wire
